>>> hw/rtl/http_chunked_decoder_macros.svh
// assertion macros shared by the chunked decoder rtl
`ifndef HTTP_CHUNKED_DECODER_MACROS_SVH
`define HTTP_CHUNKED_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define HCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define HCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/hcd_pkg.sv
// types and constants for the chunked transfer decoder
package hcd_pkg;

  localparam int LEN_W = 19;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_EXT,
    PH_DATA,
    PH_CR,
    PH_LF,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       end_of_body;
  } in_item_t;

  typedef struct packed {
    kind_t            result_kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] total_length;
  } out_item_t;

  // {valid, nibble} for an ascii hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/http_chunked_decoder.sv
// http/1.1 chunked body decoder, one body byte per item
// latency: a result item is valid the cycle after the byte that causes it is accepted
// throughput: one byte per cycle; input stalls only while a held result is stalled
// the whole parse step sits between the input handshake and the result register
// reset (rst_n, synchronous, active low): capacity returns to MAX_OUTPUT, parser to the
//   chunk-size phase with zero count, result register empty
`include "http_chunked_decoder_macros.svh"

module http_chunked_decoder #(
  parameter int MAX_OUTPUT  = 262144,
  parameter int SIZE_DIGITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hcd_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hcd_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [hcd_pkg::LEN_W-1:0]     cfg_wdata
);

  // count and capacity are wide enough for MAX_OUTPUT and for the 19-bit length field
  localparam int CAP_BITS = $clog2(MAX_OUTPUT + 1);
  localparam int CW       = (CAP_BITS > hcd_pkg::LEN_W) ? CAP_BITS : hcd_pkg::LEN_W;
  // chunk size accumulator holds SIZE_DIGITS hex digits
  localparam int SW       = 4 * SIZE_DIGITS;
  // width used to compare the chunk size against the room left
  localparam int RW       = (SW > CW) ? SW : CW;
  localparam logic [CW-1:0] MAX_CAP = CW'(MAX_OUTPUT);

  // parser state
  hcd_pkg::phase_t phase_r, phase_nxt;
  logic            digit_r, digit_nxt;
  logic [SW-1:0]   chunk_r, chunk_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   cap_r, cap_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  hcd_pkg::out_item_t out_item_r, out_item_nxt;

  logic            in_accept;
  logic [7:0]      c;
  logic            last;
  logic [4:0]      hex;
  logic            is_delim;
  logic [CW-1:0]   room;
  logic            fit_err;
  logic            has_res;
  hcd_pkg::kind_t  kind;
  logic            terminal;

  // a new byte goes in unless a finished result is held by the far side
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign c    = in_item.body_byte;
  assign last = in_item.end_of_body;
  assign hex  = hcd_pkg::hex_val(c);
  assign is_delim = (c == hcd_pkg::CH_CR) || (c == hcd_pkg::CH_LF) ||
                    (c == hcd_pkg::CH_SEMI);

  // space left for a chunk, one byte held in reserve
  assign room    = cap_r - count_r - CW'(1);
  assign fit_err = (cap_r <= count_r) || (RW'(chunk_r) > RW'(room));

  // capacity register: values above the build limit clamp to it
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we) begin
      cap_nxt = (CW'(cfg_wdata) > MAX_CAP) ? MAX_CAP : CW'(cfg_wdata);
    end
  end

  // one parse step per accepted byte
  always_comb begin
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    chunk_nxt = chunk_r;
    count_nxt = count_r;
    has_res   = 1'b0;
    kind      = hcd_pkg::KIND_DATA;

    unique case (phase_r)
      hcd_pkg::PH_SIZE: begin
        if (is_delim) begin
          if (!digit_r) begin
            // empty size line
            has_res = 1'b1;
            kind    = hcd_pkg::KIND_ERR;
          end else if (c == hcd_pkg::CH_LF) begin
            // size line ends here
            if (chunk_r == '0) begin
              has_res = 1'b1;
              kind    = hcd_pkg::KIND_DONE;
            end else if (fit_err) begin
              has_res = 1'b1;
              kind    = hcd_pkg::KIND_ERR;
            end else begin
              phase_nxt = hcd_pkg::PH_DATA;
            end
          end else begin
            // cr or extension: skip up to the line feed
            phase_nxt = hcd_pkg::PH_EXT;
          end
        end else if (!hex[4] || (chunk_r[SW-1 -: 4] != 4'd0)) begin
          // not a hex digit, or the size would not fit the accumulator
          has_res = 1'b1;
          kind    = hcd_pkg::KIND_ERR;
        end else begin
          chunk_nxt = SW'({chunk_r, hex[3:0]});
          digit_nxt = 1'b1;
        end
      end
      hcd_pkg::PH_EXT: begin
        if (c == hcd_pkg::CH_LF) begin
          if (chunk_r == '0) begin
            has_res = 1'b1;
            kind    = hcd_pkg::KIND_DONE;
          end else if (fit_err) begin
            has_res = 1'b1;
            kind    = hcd_pkg::KIND_ERR;
          end else begin
            phase_nxt = hcd_pkg::PH_DATA;
          end
        end
      end
      hcd_pkg::PH_DATA: begin
        has_res   = 1'b1;
        kind      = hcd_pkg::KIND_DATA;
        count_nxt = count_r + CW'(1);
        chunk_nxt = chunk_r - SW'(1);
        if (chunk_r == SW'(1)) begin
          phase_nxt = hcd_pkg::PH_CR;
        end
      end
      hcd_pkg::PH_CR: begin
        if (c == hcd_pkg::CH_CR) begin
          phase_nxt = hcd_pkg::PH_LF;
        end else if (c == hcd_pkg::CH_LF) begin
          phase_nxt = hcd_pkg::PH_SIZE;
          digit_nxt = 1'b0;
          chunk_nxt = '0;
        end else begin
          has_res = 1'b1;
          kind    = hcd_pkg::KIND_ERR;
        end
      end
      hcd_pkg::PH_LF: begin
        if (c == hcd_pkg::CH_LF) begin
          phase_nxt = hcd_pkg::PH_SIZE;
          digit_nxt = 1'b0;
          chunk_nxt = '0;
        end else begin
          has_res = 1'b1;
          kind    = hcd_pkg::KIND_ERR;
        end
      end
      hcd_pkg::PH_IDLE: begin
        // waiting for the end mark after done or error
      end
      default: begin
      end
    endcase

    // end mark before the zero chunk: error, even in place of a data byte
    if (last && (phase_r != hcd_pkg::PH_IDLE) &&
        !(has_res && (kind != hcd_pkg::KIND_DATA))) begin
      has_res = 1'b1;
      kind    = hcd_pkg::KIND_ERR;
    end

    terminal = has_res && (kind != hcd_pkg::KIND_DATA);
    if (terminal) begin
      phase_nxt = hcd_pkg::PH_IDLE;
    end

    // end mark restarts the parser
    if (last) begin
      phase_nxt = hcd_pkg::PH_SIZE;
      digit_nxt = 1'b0;
      chunk_nxt = '0;
      count_nxt = '0;
    end

    out_item_nxt.result_kind  = kind;
    out_item_nxt.data_byte    = (kind == hcd_pkg::KIND_DATA) ? c : 8'd0;
    out_item_nxt.total_length = (kind == hcd_pkg::KIND_DONE) ?
                                count_r[hcd_pkg::LEN_W-1:0] : '0;
  end

  // result register fills on a result, empties when taken
  always_comb begin
    if (in_accept && has_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hcd_pkg::PH_SIZE;
      digit_r     <= 1'b0;
      chunk_r     <= '0;
      count_r     <= '0;
      cap_r       <= MAX_CAP;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        phase_r <= phase_nxt;
        digit_r <= digit_nxt;
        chunk_r <= chunk_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // payload only loads with a new result
  always_ff @(posedge clk) begin
    if (in_accept && has_res) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // data phase always has bytes left in the chunk
  `HCD_ASSERT_NOW(a_data_nonempty, phase_r == hcd_pkg::PH_DATA, chunk_r != '0, "data phase with empty chunk")
  // an end-marked byte leaves the parser restarted
  `HCD_ASSERT_NEXT(a_end_restarts, in_accept && in_item.end_of_body, (phase_r == hcd_pkg::PH_SIZE) && (count_r == '0) && !digit_r, "end mark did not restart parser")
  // a byte taken in the data phase always yields a data or error result
  `HCD_ASSERT_NEXT(a_data_result, in_accept && (phase_r == hcd_pkg::PH_DATA), out_valid_r && ((out_item_r.result_kind == hcd_pkg::KIND_DATA) || (out_item_r.result_kind == hcd_pkg::KIND_ERR)), "data byte produced no result")

endmodule
